@@ hdl/bcr_pkg.sv @@
// Shared types and constants of the Big5 / CNS 11643 range converter.
`default_nettype none
package bcr_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_B2C   = 2'd1,
        OP_C2B   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic {
        CMD_FIXED  = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_kind_t;

    typedef enum logic [1:0] {
        CFG_B5L1 = 2'd0,
        CFG_B5L2 = 2'd1,
        CFG_CNS1 = 2'd2,
        CFG_CNS2 = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_CHECK,
        B_CMP,
        B_MUL,
        B_ACC,
        B_DIV,
        B_FIX,
        B_SUM,
        B_RES
    } back_state_t;

    localparam logic [1:0] CS_ASCII = 2'd0;
    localparam logic [1:0] CS_BIG5  = 2'd1;
    localparam logic [1:0] CS_CNS1  = 2'd2;
    localparam logic [1:0] CS_CNS2  = 2'd3;

    localparam logic [1:0] TBL_B5L1 = 2'd0;
    localparam logic [1:0] TBL_B5L2 = 2'd1;
    localparam logic [1:0] TBL_CNS1 = 2'd2;
    localparam logic [1:0] TBL_CNS2 = 2'd3;

    localparam logic [15:0] MISS_CODE   = 16'h003F;
    localparam logic [15:0] BIG5_FLOOR  = 16'hA140;
    localparam logic [15:0] BIG5_LVL2   = 16'hC940;
    localparam logic [15:0] BIG5_FIXED  = 16'hC94A;
    localparam logic [15:0] CNS_FIXED   = 16'h4442;

    localparam logic [7:0] RADIX_BIG5  = 8'h9D;
    localparam logic [7:0] RADIX_CNS   = 8'h5E;
    localparam logic [7:0] BIG5_BIAS   = 8'h22;
    localparam logic [7:0] CNS_TRAIL0  = 8'h21;
    localparam logic [7:0] BIG5_HI_OFS = 8'h62;
    localparam logic [7:0] BIG5_LO_OFS = 8'h40;
    localparam logic [7:0] BIG5_LO_TOP = 8'h3E;
    localparam logic [7:0] BIG5_HI_LEAD = 8'hA1;

    // reciprocals for the constant dividers, scaled by 2^22
    localparam int RECIP_SHIFT = 22;
    localparam logic [15:0] RECIP_CNS  = 16'((1 << 22) / 94);
    localparam logic [15:0] RECIP_BIG5 = 16'((1 << 22) / 157);

    typedef struct packed {
        cmd_kind_t   kind;
        logic [1:0]  tbl;
        logic [5:0]  last;
        logic [15:0] code;
        logic [1:0]  cs_hit;
        logic        wr_en;
        logic [5:0]  wr_idx;
        logic [15:0] wr_start;
        logic [15:0] wr_peer;
        logic [15:0] fix_code;
        logic [1:0]  fix_cs;
    } cmd_t;

endpackage
`default_nettype wire

@@ hdl/bcr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hdl/bcr_front.sv @@
// Front end: config registers, input beat acceptance and command classification.
`default_nettype none
module bcr_front #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [1:0]   opcode,
    input  wire logic [1:0]   table_select,
    input  wire logic [5:0]   entry_index,
    input  wire logic [15:0]  entry_start,
    input  wire logic [15:0]  entry_peer,
    input  wire logic [15:0]  code,
    input  wire logic [1:0]   charset_in,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [5:0]   cfg_data,
    input  wire logic         q_full,
    output logic              q_push,
    output bcr_pkg::cmd_t     q_cmd
);
    import bcr_pkg::*;

    logic [5:0] b5l1_reg, b5l2_reg, cns1_reg, cns2_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign q_push    = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b5l1_reg <= 6'd23;
            b5l2_reg <= 6'd46;
            cns1_reg <= 6'd24;
            cns2_reg <= 6'd47;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_B5L1: b5l1_reg <= cfg_data;
                CFG_B5L2: b5l2_reg <= cfg_data;
                CFG_CNS1: cns1_reg <= cfg_data;
                CFG_CNS2: cns2_reg <= cfg_data;
                default:  b5l1_reg <= b5l1_reg;
            endcase
        end
    end

    always_comb
    begin
        q_cmd          = '0;
        q_cmd.kind     = CMD_FIXED;
        q_cmd.code     = code;
        q_cmd.wr_idx   = entry_index;
        q_cmd.wr_start = entry_start;
        q_cmd.wr_peer  = entry_peer;
        q_cmd.fix_code = '0;
        q_cmd.fix_cs   = CS_ASCII;
        unique case (op_t'(opcode))
            OP_WRITE:
            begin
                q_cmd.tbl   = table_select;
                q_cmd.wr_en = (int'(entry_index) < TABLE_DEPTH);
            end
            OP_B2C:
            begin
                q_cmd.cs_hit = CS_CNS1;
                if (code < BIG5_LVL2)
                begin
                    q_cmd.kind = CMD_SEARCH;
                    q_cmd.tbl  = TBL_B5L1;
                    q_cmd.last = b5l1_reg;
                end
                else if (code == BIG5_FIXED)
                begin
                    q_cmd.fix_code = CNS_FIXED;
                    q_cmd.fix_cs   = CS_CNS1;
                end
                else
                begin
                    q_cmd.kind   = CMD_SEARCH;
                    q_cmd.tbl    = TBL_B5L2;
                    q_cmd.last   = b5l2_reg;
                    q_cmd.cs_hit = CS_CNS2;
                end
            end
            OP_C2B:
            begin
                q_cmd.cs_hit = CS_BIG5;
                if (charset_in == 2'd0)
                begin
                    q_cmd.kind = CMD_SEARCH;
                    q_cmd.tbl  = TBL_CNS1;
                    q_cmd.last = cns1_reg;
                end
                else if (charset_in == 2'd1)
                begin
                    q_cmd.kind = CMD_SEARCH;
                    q_cmd.tbl  = TBL_CNS2;
                    q_cmd.last = cns2_reg;
                end
                else
                begin
                    q_cmd.fix_code = MISS_CODE;
                end
            end
            default:
            begin
                q_cmd.fix_code = '0;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ hdl/bcr_queue.sv @@
// Two-entry command queue between front end and back end.
`default_nettype none
module bcr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire bcr_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output bcr_pkg::cmd_t      pop_cmd,
    output logic               empty
);
    import bcr_pkg::*;

    cmd_t       slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_cmd = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

@@ hdl/bcr_back.sv @@
// Back end: table store, binary search sequencer, code mapping, output register.
`default_nettype none
module bcr_back #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire bcr_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [15:0]        code_out,
    output logic [1:0]         charset_out
);
    import bcr_pkg::*;

    localparam int AW = $clog2(4 * TABLE_DEPTH);
    localparam int SW = $clog2(TABLE_DEPTH) + 2;

    back_state_t state_reg, state_next;
    cmd_t  cmd_reg, cmd_next;
    logic signed [SW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next, mid_c;
    logic [15:0] st_reg, st_next, pr_reg, pr_next;
    logic signed [17:0] prod_reg, prod_next;
    logic        neg_reg, neg_next;
    logic [17:0] mag_reg, mag_next;
    logic [11:0] qe_reg, qe_next;
    logic signed [12:0] q_reg, q_next;
    logic signed [8:0]  r_reg, r_next;
    logic [15:0] res_code_reg, res_code_next;
    logic [1:0]  res_cs_reg, res_cs_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] code_out_reg, code_out_next;
    logic [1:0]  cs_out_reg, cs_out_next;

    logic        we;
    logic [AW-1:0] waddr, base, raddr_a, raddr_b;
    logic [31:0] rdata_a, rdata_b;
    logic        hit, out_free, is_big5;
    logic [15:0] st_c, nx_c, pr_c;
    logic signed [8:0]  rows;
    logic signed [18:0] acc_c, bias_c, ofs_c;
    logic [33:0] qprod;
    logic [17:0] rm_c;
    logic [7:0]  divisor;
    logic [11:0] qm_c;
    logic [8:0]  rmag_c;
    logic [15:0] sum_c, low_ofs;

    bcr_ram #(.WIDTH(32), .DEPTH(4 * TABLE_DEPTH)) u_ram_lo (
        .clk(clk), .we(we), .waddr(waddr), .wdata({q_cmd.wr_peer, q_cmd.wr_start}),
        .raddr(raddr_a), .rdata(rdata_a)
    );
    bcr_ram #(.WIDTH(32), .DEPTH(4 * TABLE_DEPTH)) u_ram_hi (
        .clk(clk), .we(we), .waddr(waddr), .wdata({q_cmd.wr_peer, q_cmd.wr_start}),
        .raddr(raddr_b), .rdata(rdata_b)
    );

    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign we       = q_pop && q_cmd.wr_en;
    assign waddr    = AW'(q_cmd.tbl) * AW'(TABLE_DEPTH) + AW'(q_cmd.wr_idx);
    assign base     = AW'(cmd_reg.tbl) * AW'(TABLE_DEPTH);
    assign mid_c    = SW'((lo_reg + hi_reg) >>> 1);
    assign raddr_a  = base + AW'($unsigned(mid_c));
    assign raddr_b  = base + AW'($unsigned(mid_c)) + AW'(1);
    assign st_c     = rdata_a[15:0];
    assign pr_c     = rdata_a[31:16];
    assign nx_c     = rdata_b[15:0];
    assign hit      = (st_c <= cmd_reg.code) && (nx_c > cmd_reg.code);
    assign out_free = !out_valid_reg || !out_stall;
    assign is_big5  = (cmd_reg.code >= BIG5_FLOOR);
    assign divisor  = is_big5 ? RADIX_CNS : RADIX_BIG5;

    assign out_valid   = out_valid_reg;
    assign code_out    = code_out_reg;
    assign charset_out = cs_out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (!q_empty) state_next = (q_cmd.kind == CMD_SEARCH) ? B_CHECK : B_RES;
            B_CHECK: state_next = (lo_reg > hi_reg) ? B_RES : B_CMP;
            B_CMP:   state_next = hit ? ((pr_c == '0) ? B_RES : B_MUL) : B_CHECK;
            B_MUL:   state_next = B_ACC;
            B_ACC:   state_next = B_DIV;
            B_DIV:   state_next = B_FIX;
            B_FIX:   state_next = B_SUM;
            B_SUM:   state_next = B_RES;
            B_RES:   if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // mapping arithmetic
    always_comb
    begin
        rows = $signed({1'b0, cmd_reg.code[15:8]}) - $signed({1'b0, st_reg[15:8]});
        if (is_big5)
        begin
            if (cmd_reg.code[7:0] >= BIG5_HI_LEAD)
                bias_c = (st_reg[7:0] >= BIG5_HI_LEAD) ? 19'sd0 : -$signed({11'd0, BIG5_BIAS});
            else
                bias_c = (st_reg[7:0] >= BIG5_HI_LEAD) ? $signed({11'd0, BIG5_BIAS}) : 19'sd0;
            ofs_c = bias_c - $signed({11'd0, CNS_TRAIL0});
        end
        else
        begin
            bias_c = 19'sd0;
            ofs_c  = (pr_reg[7:0] >= BIG5_HI_LEAD) ? -$signed({11'd0, BIG5_HI_OFS})
                                                 : -$signed({11'd0, BIG5_LO_OFS});
        end
        acc_c = 19'(prod_reg) + $signed({11'd0, cmd_reg.code[7:0]})
              - $signed({11'd0, st_reg[7:0]}) + $signed({11'd0, pr_reg[7:0]}) + ofs_c;
        qprod = 34'(mag_reg) * 34'(is_big5 ? RECIP_CNS : RECIP_BIG5);
        rm_c  = mag_reg - 18'(qe_reg) * 18'(divisor);
        if (rm_c >= 18'(divisor))
        begin
            qm_c   = qe_reg + 12'd1;
            rmag_c = 9'(rm_c - 18'(divisor));
        end
        else
        begin
            qm_c   = qe_reg;
            rmag_c = 9'(rm_c);
        end
        if (is_big5)
            low_ofs = 16'(CNS_TRAIL0);
        else
            low_ofs = (r_reg > $signed({1'b0, BIG5_LO_TOP})) ? 16'(BIG5_HI_OFS)
                                                           : 16'(BIG5_LO_OFS);
        sum_c = {pr_reg[15:8], 8'h00} + {q_reg[7:0], 8'h00} + low_ofs
              + 16'($signed(r_reg));
    end

    // register updates
    always_comb
    begin
        cmd_next       = cmd_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        st_next        = st_reg;
        pr_next        = pr_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        qe_next        = qe_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        res_code_next  = res_code_reg;
        res_cs_next    = res_cs_reg;
        out_valid_next = out_valid_reg && out_stall;
        code_out_next  = code_out_reg;
        cs_out_next    = cs_out_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    cmd_next      = q_cmd;
                    lo_next       = '0;
                    hi_next       = (int'(q_cmd.last) > TABLE_DEPTH - 2)
                                  ? SW'(TABLE_DEPTH - 2) : SW'(q_cmd.last);
                    res_code_next = q_cmd.fix_code;
                    res_cs_next   = q_cmd.fix_cs;
                end
            end
            B_CHECK:
            begin
                mid_next = mid_c;
                if (lo_reg > hi_reg)
                begin
                    res_code_next = MISS_CODE;
                    res_cs_next   = CS_ASCII;
                end
            end
            B_CMP:
            begin
                if (hit)
                begin
                    st_next = st_c;
                    pr_next = pr_c;
                    if (pr_c == '0)
                    begin
                        res_code_next = MISS_CODE;
                        res_cs_next   = CS_ASCII;
                    end
                end
                else if (st_c > cmd_reg.code)
                    hi_next = mid_reg - SW'(1);
                else
                    lo_next = mid_reg + SW'(1);
            end
            B_MUL:
            begin
                prod_next = rows * $signed({1'b0, is_big5 ? RADIX_BIG5 : RADIX_CNS});
            end
            B_ACC:
            begin
                neg_next = acc_c[18];
                mag_next = acc_c[18] ? 18'(-acc_c) : 18'(acc_c);
            end
            B_DIV:
            begin
                qe_next = qprod[RECIP_SHIFT +: 12];
            end
            B_FIX:
            begin
                q_next = neg_reg ? -$signed({1'b0, qm_c}) : $signed({1'b0, qm_c});
                r_next = neg_reg ? -$signed(rmag_c) : $signed(rmag_c);
            end
            B_SUM:
            begin
                res_code_next = (sum_c == '0) ? MISS_CODE : sum_c;
                res_cs_next   = (sum_c == '0) ? CS_ASCII : cmd_reg.cs_hit;
            end
            B_RES:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    code_out_next  = res_code_reg;
                    cs_out_next    = res_cs_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        st_reg       <= st_next;
        pr_reg       <= pr_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        qe_reg       <= qe_next;
        q_reg        <= q_next;
        r_reg        <= r_next;
        res_code_reg <= res_code_next;
        res_cs_reg   <= res_cs_next;
        code_out_reg <= code_out_next;
        cs_out_reg   <= cs_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // every probe stays inside the table, end entry included
    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CMP |-> (mid_reg >= 0) && (mid_reg <= SW'(TABLE_DEPTH - 2)))
        else $error("probe index out of table");
    // the table is only written when a command leaves the queue
    a_write_pop: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> q_pop && state_reg == B_IDLE)
        else $error("table write outside command pop");
    // a result loads the output register only from the result state
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == B_RES)
        else $error("output loaded outside result state");
    // ASCII answers are either a miss or an acknowledgement
    a_ascii_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && cs_out_reg == CS_ASCII |->
            code_out_reg == MISS_CODE || code_out_reg == 16'h0000)
        else $error("ASCII result with converted code");
`endif
endmodule
`default_nettype wire

@@ hdl/big5_cns_range_converter_unit.sv @@
// Top level of the Big5 / CNS 11643 range converter.
// Converts Big5 codes to CNS 11643 planes 1 and 2 and back through four range
// tables held in an on-chip store that input beats load (opcode 0) before
// conversions (opcode 1 Big5 to CNS, opcode 2 CNS to Big5). Every input beat
// yields exactly one output beat: zero / ASCII for a write, the mapped code,
// or 0x3F ASCII on a miss. The front end takes a beat in the cycle it arrives
// while the two-entry command queue has room; the back end works on one
// command at a time, at the earliest the cycle after the beat is queued. A write
// or a fixed answer passes the back end through command pop and output load.
// A conversion takes a command pop, then for each binary-search probe a table
// read through the registered store ports and then a compare, up to
// floor(log2(last+1))+1 probes, then on a hit the mapping steps multiply,
// accumulate, reciprocal divide, correction, sum and output load; the output
// load alone when the hit range is unmapped; or a final check and the output
// load when the search runs out. The search loop over the store sets the
// throughput. Configuration registers hold the last searched index of each
// table; cfg_ready is always high and writes are to be made while idle.
// The table store has no reset: searches must only touch written entries.
`default_nettype none
module big5_cns_range_converter_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [1:0]  table_select,
    input  wire logic [5:0]  entry_index,
    input  wire logic [15:0] entry_start,
    input  wire logic [15:0] entry_peer,
    input  wire logic [15:0] code,
    input  wire logic [1:0]  charset_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      code_out,
    output logic [1:0]       charset_out,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [5:0]  cfg_data
);
    import bcr_pkg::*;

    cmd_t push_cmd, pop_cmd;
    logic push, q_full, q_empty, pop;

    // front: accept and classify beats, hold config
    bcr_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .table_select(table_select), .entry_index(entry_index),
        .entry_start(entry_start), .entry_peer(entry_peer), .code(code),
        .charset_in(charset_in),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .q_full(q_full), .q_push(push), .q_cmd(push_cmd)
    );

    // decoupling queue
    bcr_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_cmd(push_cmd), .full(q_full),
        .pop(pop), .pop_cmd(pop_cmd), .empty(q_empty)
    );

    // back: store, search, mapping, output register
    bcr_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_empty(q_empty), .q_cmd(pop_cmd), .q_pop(pop),
        .out_valid(out_valid), .out_stall(out_stall),
        .code_out(code_out), .charset_out(charset_out)
    );
endmodule
`default_nettype wire
